// ----- hw/rtl/box_blur_3x3_edge_aware_macros.svh -----
// Assertion macros shared by the blur block.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BB3_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/bb3_pkg.sv -----
// Types, constants and helpers shared by the blur block.
package bb3_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int MAX_HEIGHT   = 4095;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int ROW_W        = 12;
  localparam int CFG_WIDTH_W  = 11;
  localparam int CFG_HEIGHT_W = 12;
  localparam int CFG_DATA_W   = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int CHAN_W       = 8;
  localparam int NUM_CHAN     = 3;
  localparam int PIX_W        = NUM_CHAN * CHAN_W;
  localparam int NUM_LINES    = 3;
  localparam int SLOT_W       = 2;
  localparam int SUM_W        = 12;
  localparam int CNT_W        = 4;
  localparam int NUM_W        = SUM_W + 1;
  localparam int DEN_W        = CNT_W + 1;
  localparam int DIV_STEPS    = NUM_W;
  localparam int ITER_W       = $clog2(DIV_STEPS);

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    COL_LEFT  = 2'd0,
    COL_MID   = 2'd1,
    COL_RIGHT = 2'd2
  } col_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_last;
  } pix_out_t;

  typedef struct packed {
    logic     latch;
    logic     eval;
    col_sel_e rd_col;
    logic     acc_en;
    col_sel_e acc_col;
    logic     div_load;
    logic     div_step;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit;
    logic div_last;
    logic out_free;
  } dp_status_t;

  function automatic slot_t slot_inc(slot_t s);
    slot_t r;
    r = (s == slot_t'(NUM_LINES - 1)) ? slot_t'(0) : s + slot_t'(1);
    return r;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    slot_t r;
    r = (s == slot_t'(0)) ? slot_t'(NUM_LINES - 1) : s - slot_t'(1);
    return r;
  endfunction

endpackage

// ----- hw/rtl/box_blur_3x3_edge_aware.sv -----
// Top level of the edge-aware 3x3 box blur.
//
// Pixels enter in raster order on the in channel (valid/ready); op selects a
// data pixel or a flush item. Each pixel leaves on the out channel replaced
// by the rounded mean of its in-image 3x3 neighborhood, one row plus one
// pixel behind the input. Once the frame is complete, every further item
// (flush or data, data dropped) drains one result; the last is flagged
// with frame_last and the block is ready for the next frame.
// An item that yields no result ends after the decide step; one that yields
// a result goes through decide, three column reads of the three line RAMs,
// a 13-step restoring divider with one lane per channel, and the load of
// the output register. One item is in work at a time.
// A result waits in the output register while the receiver stalls; a new
// item is still accepted and worked on, and holds in its last step until
// the register frees up.
// Reset sets width 640 and height 480 and clears positions; the line RAMs
// are not cleared. A write on the cfg port restarts the frame.
`include "box_blur_3x3_edge_aware_macros.svh"

module box_blur_3x3_edge_aware import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bb3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bb3_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  `BB3_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `BB3_ASSERT_NOW(a_no_overwrite, cmd.out_load, status.out_free, "result overwritten")
  `BB3_ASSERT_NOW(a_eval_after_accept, cmd.eval, $past(in_valid_i && in_ready_o), "eval w/o item")

endmodule

// ----- hw/rtl/bb3_ram.sv -----
// Generic simple dual-port RAM with registered read.
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bb3_ctrl.sv -----
// Sequencer for one item: evaluate, read window, divide, emit.
module bb3_ctrl import bb3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = status_i.emit ? ST_RD0 : ST_IDLE;
      end
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_RD3;
      ST_RD3:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.rd_col   = COL_LEFT;
    cmd_o.acc_col  = COL_LEFT;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_RD0:  cmd_o.rd_col = COL_LEFT;
      ST_RD1: begin
        cmd_o.rd_col  = COL_MID;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_col = COL_LEFT;
      end
      ST_RD2: begin
        cmd_o.rd_col  = COL_RIGHT;
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_col = COL_MID;
      end
      ST_RD3: begin
        cmd_o.acc_en  = 1'b1;
        cmd_o.acc_col = COL_RIGHT;
      end
      ST_LOAD: cmd_o.div_load = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_OUT:  cmd_o.out_load = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- hw/rtl/bb3_datapath.sv -----
// Line stores, position counters, window sums, divider and output register.
module bb3_datapath import bb3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pix_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctrl_cmd_t             cmd_i,
  output dp_status_t            status_o
);

  logic [CFG_WIDTH_W-1:0]  width_q, width_d;
  logic [CFG_HEIGHT_W-1:0] height_q, height_d;
  logic [CFG_WIDTH_W-1:0]  w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;

  logic [COL_W-1:0]       in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]       in_row_q, in_row_d, out_row_q, out_row_d;
  slot_t                  in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic                   frame_done_q, frame_done_d;
  logic [CFG_WIDTH_W-1:0] lag_q, lag_d;
  logic                   out_valid_q, out_valid_d;
  logic [ITER_W-1:0]      iter_q, iter_d;

  pix_in_t                item_q;
  logic [SUM_W-1:0]       sum_q [NUM_CHAN];
  logic [CNT_W-1:0]       cnt_q;
  logic [NUM_W-1:0]       num_q [NUM_CHAN];
  logic [DEN_W-1:0]       rem_q [NUM_CHAN];
  logic [DEN_W-1:0]       den_q;
  pix_out_t               out_data_q;

  logic [CFG_WIDTH_W-1:0] in_col_inc, out_col_inc;
  logic [ROW_W:0]         in_row_inc, out_row_inc;
  logic                   in_col_wrap, in_row_end, fd_new, is_pix, do_write;
  logic                   out_col_wrap, out_last, restart;
  logic [ROW_W:0]         lag_need;

  logic [COL_W-1:0]       rd_addr;
  logic [PIX_W-1:0]       rdata [NUM_LINES];
  logic [NUM_LINES-1:0]   row_ok;
  logic [1:0]             rows_cnt;
  logic                   col_ok;
  slot_t                  next_slot, prev_slot;

  // Effective geometry.
  always_comb begin
    if (width_q == '0) begin
      w_eff = CFG_WIDTH_W'(1);
    end else if (width_q > CFG_WIDTH_W'(MAX_WIDTH)) begin
      w_eff = CFG_WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = CFG_HEIGHT_W'(1);
    end else if (height_q > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
      h_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign in_col_inc   = CFG_WIDTH_W'(in_col_q) + CFG_WIDTH_W'(1);
  assign in_col_wrap  = in_col_inc >= w_eff;
  assign in_row_inc   = {1'b0, in_row_q} + (ROW_W+1)'(1);
  assign in_row_end   = in_row_inc >= {1'b0, h_eff};
  assign fd_new       = in_col_wrap && in_row_end;
  assign is_pix       = (item_q.op == OP_PIXEL) && !frame_done_q;
  assign lag_need     = (ROW_W+1)'(w_eff) + (ROW_W+1)'(1);
  assign do_write     = cmd_i.eval && is_pix;

  assign out_col_inc  = CFG_WIDTH_W'(out_col_q) + CFG_WIDTH_W'(1);
  assign out_col_wrap = out_col_inc >= w_eff;
  assign out_row_inc  = {1'b0, out_row_q} + (ROW_W+1)'(1);
  assign out_last     = out_col_wrap && (out_row_inc >= {1'b0, h_eff});
  assign restart      = cfg_we_i || (cmd_i.out_load && out_last);

  assign status_o.emit     = frame_done_q
                             || (is_pix && (fd_new || ((ROW_W+1)'(lag_q) >= lag_need)));
  assign status_o.div_last = iter_q == ITER_W'(DIV_STEPS - 1);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Configuration registers.
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_d  = CFG_WIDTH_W'(cfg_data_i);
        REG_IMAGE_HEIGHT: height_d = CFG_HEIGHT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Position counters.
  always_comb begin
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    in_slot_d    = in_slot_q;
    out_col_d    = out_col_q;
    out_row_d    = out_row_q;
    out_slot_d   = out_slot_q;
    frame_done_d = frame_done_q;
    lag_d        = lag_q;
    if (restart) begin
      in_col_d     = '0;
      in_row_d     = '0;
      in_slot_d    = '0;
      out_col_d    = '0;
      out_row_d    = '0;
      out_slot_d   = '0;
      frame_done_d = 1'b0;
      lag_d        = '0;
    end else if (do_write) begin
      lag_d = lag_q + CFG_WIDTH_W'(1);
      if (in_col_wrap) begin
        in_col_d  = '0;
        in_row_d  = in_row_inc[ROW_W-1:0];
        in_slot_d = slot_inc(in_slot_q);
        if (in_row_end) frame_done_d = 1'b1;
      end else begin
        in_col_d = in_col_inc[COL_W-1:0];
      end
    end else if (cmd_i.out_load) begin
      lag_d = lag_q - CFG_WIDTH_W'(1);
      if (out_col_wrap) begin
        out_col_d  = '0;
        out_row_d  = out_row_inc[ROW_W-1:0];
        out_slot_d = slot_inc(out_slot_q);
      end else begin
        out_col_d = out_col_inc[COL_W-1:0];
      end
    end
  end

  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign iter_d      = cmd_i.div_load ? '0 : (cmd_i.div_step ? iter_q + ITER_W'(1) : iter_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= CFG_WIDTH_W'(640);
      height_q     <= CFG_HEIGHT_W'(480);
      in_col_q     <= '0;
      in_row_q     <= '0;
      in_slot_q    <= '0;
      out_col_q    <= '0;
      out_row_q    <= '0;
      out_slot_q   <= '0;
      frame_done_q <= 1'b0;
      lag_q        <= '0;
      out_valid_q  <= 1'b0;
      iter_q       <= '0;
    end else begin
      width_q      <= width_d;
      height_q     <= height_d;
      in_col_q     <= in_col_d;
      in_row_q     <= in_row_d;
      in_slot_q    <= in_slot_d;
      out_col_q    <= out_col_d;
      out_row_q    <= out_row_d;
      out_slot_q   <= out_slot_d;
      frame_done_q <= frame_done_d;
      lag_q        <= lag_d;
      out_valid_q  <= out_valid_d;
      iter_q       <= iter_d;
    end
  end

  // Line stores, one per row slot; all three read at the same column.
  assign rd_addr = out_col_q + COL_W'(cmd_i.rd_col) - COL_W'(1);

  for (genvar k = 0; k < NUM_LINES; k++) begin : g_line
    bb3_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk_i   (clk_i),
      .we_i    (do_write && (in_slot_q == slot_t'(k))),
      .waddr_i (in_col_q),
      .wdata_i ({item_q.red, item_q.green, item_q.blue}),
      .raddr_i (rd_addr),
      .rdata_o (rdata[k])
    );
  end

  assign next_slot = slot_inc(out_slot_q);
  assign prev_slot = slot_dec(out_slot_q);

  always_comb begin
    for (int k = 0; k < NUM_LINES; k++) begin
      row_ok[k] = (out_slot_q == slot_t'(k))
                  || ((next_slot == slot_t'(k)) && (out_row_inc < {1'b0, h_eff}))
                  || ((prev_slot == slot_t'(k)) && (out_row_q != '0));
    end
    rows_cnt = 2'($countones(row_ok));
    unique case (cmd_i.acc_col)
      COL_LEFT:  col_ok = out_col_q != '0;
      COL_MID:   col_ok = 1'b1;
      COL_RIGHT: col_ok = !out_col_wrap;
      default:   col_ok = 1'b0;
    endcase
  end

  // Item latch, window sums, divider lanes and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= in_data_i;
    end
    if (cmd_i.eval) begin
      cnt_q <= '0;
    end else if (cmd_i.acc_en && col_ok) begin
      cnt_q <= cnt_q + CNT_W'(rows_cnt);
    end
    if (cmd_i.div_load) begin
      den_q <= {cnt_q, 1'b0};
    end
    if (cmd_i.out_load) begin
      out_data_q.out_red    <= num_q[0][CHAN_W-1:0];
      out_data_q.out_green  <= num_q[1][CHAN_W-1:0];
      out_data_q.out_blue   <= num_q[2][CHAN_W-1:0];
      out_data_q.frame_last <= out_last;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    localparam int Lsb = (NUM_CHAN - 1 - c) * CHAN_W;
    logic [SUM_W-1:0] col_sum;
    logic [DEN_W:0]   trial;
    logic             qbit;

    always_comb begin
      col_sum = '0;
      for (int k = 0; k < NUM_LINES; k++) begin
        if (row_ok[k]) col_sum = col_sum + SUM_W'(rdata[k][Lsb +: CHAN_W]);
      end
      trial = {rem_q[c], num_q[c][NUM_W-1]};
      qbit  = trial >= {1'b0, den_q};
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.eval) begin
        sum_q[c] <= '0;
      end else if (cmd_i.acc_en && col_ok) begin
        sum_q[c] <= sum_q[c] + col_sum;
      end
      if (cmd_i.div_load) begin
        num_q[c] <= {sum_q[c], 1'b0} + NUM_W'(cnt_q);
        rem_q[c] <= '0;
      end else if (cmd_i.div_step) begin
        num_q[c] <= {num_q[c][NUM_W-2:0], qbit};
        rem_q[c] <= qbit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
